### hw/rtl/relay_pulse_burst_gate_assert.svh
// Assertion macros for the relay pulse burst gate.
`ifndef RELAY_PULSE_BURST_GATE_ASSERT_SVH
`define RELAY_PULSE_BURST_GATE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on clk, off while rst_n is low.
`define RPBG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpbg assertion failed");
// Next-cycle implication, checked on clk, off while rst_n is low.
`define RPBG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpbg assertion failed");
`else
`define RPBG_ASSERT_NOW(lbl, ante, cons)
`define RPBG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/rpbg_pkg.sv
// Shared widths, command codes and constants for the relay pulse burst gate.
package rpbg_pkg;

  localparam int CMD_W    = 2;
  localparam int POD_W    = 3;
  localparam int FREQ_W   = 16;
  localparam int DUR_W    = 16;
  localparam int INTEN_W  = 7;
  localparam int RELAY_W  = 6;
  localparam int DUTY_W   = 16;
  localparam int PERIOD_W = 8;
  localparam int PHASE_W  = 16;
  localparam int PROD_W   = PERIOD_W + FREQ_W;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_TICK = 2'd0;
  localparam cmd_t CMD_FIRE = 2'd1;
  localparam cmd_t CMD_STOP = 2'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd93;
  localparam logic [INTEN_W-1:0]  MAX_INTENSITY = 7'd100;
  localparam int                  CYCLE_TICKS   = 1000;
  localparam int                  ON_SCALE      = CYCLE_TICKS / 100;
  localparam int                  LEN_W         = 10;

  // duty = prod / 144 = (prod >> 4) / 9; the /9 is a reciprocal multiply,
  // exact for quotients of a 20-bit dividend.
  localparam int DUTY_PRE_SHIFT = 4;
  localparam int DUTY_ODD       = 9;
  localparam int DIVD_W         = PROD_W - DUTY_PRE_SHIFT;
  localparam int RECIP_SHIFT    = DIVD_W + 4;
  localparam int RECIP_W        = RECIP_SHIFT - 2;
  localparam logic [RECIP_W-1:0] DUTY_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + DUTY_ODD - 1) / DUTY_ODD);
  localparam int QUOT_W         = DUTY_W + 1;

endpackage

### hw/rtl/rpbg_if.sv
// Input and result channel interfaces for the relay pulse burst gate.
interface rpbg_in_if
  import rpbg_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [POD_W-1:0]   pod;
  logic [FREQ_W-1:0]  freq_value;
  logic [DUR_W-1:0]   duration_ticks;
  logic [INTEN_W-1:0] intensity_pct;

  modport source (output valid, cmd, pod, freq_value, duration_ticks, intensity_pct,
                  input ready);
  modport sink (input valid, cmd, pod, freq_value, duration_ticks, intensity_pct,
                output ready);
endinterface

interface rpbg_out_if
  import rpbg_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [RELAY_W-1:0] relay_mask;
  logic               right_pwm_on;
  logic               left_pwm_on;
  logic               timebase_on;
  logic [DUTY_W-1:0]  duty;
  logic               busy_res;

  modport source (output valid, relay_mask, right_pwm_on, left_pwm_on, timebase_on,
                  duty, busy_res, input ready);
  modport sink (input valid, relay_mask, right_pwm_on, left_pwm_on, timebase_on,
                duty, busy_res, output ready);
endinterface

### hw/rtl/relay_pulse_burst_gate.sv
// Relay pulse burst gate: relay select, PWM gating and burst timing top level.
// Path: the input register, then the state/result register; together they form
//   a two-deep pipeline, and the duty multiply sits at the input register.
// Throughput: one transaction per cycle while the result is not stalled.
// Reset: synchronous active-low rst_n clears pipeline valids and all burst state;
//   pwm_period returns to 93 and held intensity to 100.
`include "relay_pulse_burst_gate_assert.svh"

module relay_pulse_burst_gate
  import rpbg_pkg::*;
#(
  parameter int NUM_PODS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  rpbg_in_if.sink             in_chan,
  rpbg_out_if.source          out_chan,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_wdata
);

  localparam int RIGHT_PODS = NUM_PODS / 2;
  localparam int POD_SPACE  = 1 << POD_W;

  // ---------------------------------------------------------------------------
  // Configuration: PWM period; the user must write it only while idle (unchecked).
  // ---------------------------------------------------------------------------
  logic [PERIOD_W-1:0] pwm_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      pwm_period_r <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. Stage 1 holds the accepted transaction; the state registers
  // double as the result register, so they only update when the result slot
  // is free or being drained.
  // ---------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic in_fire;
  logic adv;

  assign adv            = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || adv;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 payload: fields plus period * freq product (one 8x16 multiply).
  // ---------------------------------------------------------------------------
  cmd_t               s1_cmd_r;
  logic [POD_W-1:0]   s1_pod_r;
  logic [DUR_W-1:0]   s1_dur_r;
  logic [INTEN_W-1:0] s1_inten_r;
  logic [PROD_W-1:0]  s1_prod_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r   <= in_chan.cmd;
      s1_pod_r   <= in_chan.pod;
      s1_dur_r   <= in_chan.duration_ticks;
      s1_inten_r <= in_chan.intensity_pct;
      s1_prod_r  <= PROD_W'(pwm_period_r) * PROD_W'(in_chan.freq_value);
    end
  end

  // Duty: prod / 144 via shift and reciprocal multiply, then saturate to 16 bits.
  logic [DIVD_W-1:0]              divd;
  logic [DIVD_W+RECIP_W-1:0]      quot_full;
  logic [QUOT_W-1:0]              quot;
  logic [DUTY_W-1:0]              duty_sat;

  assign divd      = s1_prod_r[PROD_W-1:DUTY_PRE_SHIFT];
  assign quot_full = (DIVD_W+RECIP_W)'(divd) * (DIVD_W+RECIP_W)'(DUTY_RECIP);
  assign quot      = quot_full[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
  assign duty_sat  = quot[QUOT_W-1] ? {DUTY_W{1'b1}} : quot[DUTY_W-1:0];

  // ---------------------------------------------------------------------------
  // Burst state
  // ---------------------------------------------------------------------------
  logic                active_r, active_nxt;
  logic [POD_W-1:0]    pod_idx_r, pod_idx_nxt;
  logic [NUM_PODS-1:0] relays_r, relays_nxt;
  logic                right_en_r, right_en_nxt;
  logic                left_en_r, left_en_nxt;
  logic                timebase_r, timebase_nxt;
  logic [INTEN_W-1:0]  inten_r, inten_nxt;
  logic [DUR_W-1:0]    remain_r, remain_nxt;
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic                phase_on_r, phase_on_nxt;
  logic [DUTY_W-1:0]   duty_r, duty_nxt;

  logic                pod_ok;
  logic                pod_right;
  logic                act_right;
  logic [NUM_PODS-1:0] pod_onehot;
  logic [PHASE_W-1:0]  phase_inc;
  logic [LEN_W-1:0]    on_len;
  logic [LEN_W-1:0]    off_len;

  assign pod_ok    = {1'b0, s1_pod_r} < (POD_W+1)'(NUM_PODS);
  assign pod_right = {1'b0, s1_pod_r} < (POD_W+1)'(RIGHT_PODS);
  assign act_right = {1'b0, pod_idx_r} < (POD_W+1)'(RIGHT_PODS);
  assign phase_inc = phase_r + PHASE_W'(1);
  assign on_len    = LEN_W'(inten_r) * LEN_W'(ON_SCALE);
  assign off_len   = LEN_W'(CYCLE_TICKS) - on_len;

  always_comb begin
    for (int i = 0; i < NUM_PODS; i++) begin
      pod_onehot[i] = (s1_pod_r == POD_W'(i));
    end
  end

  always_comb begin
    active_nxt   = active_r;
    pod_idx_nxt  = pod_idx_r;
    relays_nxt   = relays_r;
    right_en_nxt = right_en_r;
    left_en_nxt  = left_en_r;
    timebase_nxt = timebase_r;
    inten_nxt    = inten_r;
    remain_nxt   = remain_r;
    phase_nxt    = phase_r;
    phase_on_nxt = phase_on_r;
    duty_nxt     = duty_r;

    unique case (s1_cmd_r)
      CMD_TICK: begin
        if (active_r) begin
          phase_nxt = phase_inc;
          if (phase_on_r) begin
            // on phase over: gates and timebase off
            if (phase_inc >= PHASE_W'(on_len)) begin
              right_en_nxt = 1'b0;
              left_en_nxt  = 1'b0;
              timebase_nxt = 1'b0;
              phase_on_nxt = 1'b0;
              phase_nxt    = '0;
            end
          end else if (phase_inc >= PHASE_W'(off_len)) begin
            // off phase over: restart the active pod's gate
            if (act_right) begin
              right_en_nxt = 1'b1;
            end else begin
              left_en_nxt = 1'b1;
            end
            timebase_nxt = 1'b1;
            phase_on_nxt = 1'b1;
            phase_nxt    = '0;
          end
          // burst countdown; zero means run until stopped
          if (remain_r != '0) begin
            if (remain_r > DUR_W'(1)) begin
              remain_nxt = remain_r - DUR_W'(1);
            end else begin
              right_en_nxt = 1'b0;
              left_en_nxt  = 1'b0;
              timebase_nxt = 1'b0;
              relays_nxt   = '0;
              active_nxt   = 1'b0;
              remain_nxt   = '0;
              phase_on_nxt = 1'b0;
            end
          end
        end
      end
      CMD_FIRE: begin
        if (pod_ok) begin
          relays_nxt = pod_onehot;
          duty_nxt   = duty_sat;
          // the other side's gate is left as it was
          if (pod_right) begin
            right_en_nxt = 1'b1;
          end else begin
            left_en_nxt = 1'b1;
          end
          timebase_nxt = 1'b1;
          active_nxt   = 1'b1;
          pod_idx_nxt  = s1_pod_r;
          inten_nxt    = (s1_inten_r > MAX_INTENSITY) ? MAX_INTENSITY : s1_inten_r;
          remain_nxt   = s1_dur_r;
          phase_nxt    = '0;
          phase_on_nxt = 1'b1;
        end
      end
      CMD_STOP: begin
        // pod index, phase count and duty are kept
        right_en_nxt = 1'b0;
        left_en_nxt  = 1'b0;
        timebase_nxt = 1'b0;
        relays_nxt   = '0;
        active_nxt   = 1'b0;
        remain_nxt   = '0;
        phase_on_nxt = 1'b0;
      end
      default: begin
        // reserved command: no change
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      pod_idx_r  <= '0;
      relays_r   <= '0;
      right_en_r <= 1'b0;
      left_en_r  <= 1'b0;
      timebase_r <= 1'b0;
      inten_r    <= MAX_INTENSITY;
      remain_r   <= '0;
      phase_r    <= '0;
      phase_on_r <= 1'b0;
      duty_r     <= '0;
    end else if (adv) begin
      active_r   <= active_nxt;
      pod_idx_r  <= pod_idx_nxt;
      relays_r   <= relays_nxt;
      right_en_r <= right_en_nxt;
      left_en_r  <= left_en_nxt;
      timebase_r <= timebase_nxt;
      inten_r    <= inten_nxt;
      remain_r   <= remain_nxt;
      phase_r    <= phase_nxt;
      phase_on_r <= phase_on_nxt;
      duty_r     <= duty_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result transaction: straight from the state registers. Relays past bit 5
  // are dropped from the mask.
  // ---------------------------------------------------------------------------
  logic [POD_SPACE-1:0] relays_wide;

  assign relays_wide           = POD_SPACE'(relays_r);
  assign out_chan.relay_mask   = relays_wide[RELAY_W-1:0];
  assign out_chan.right_pwm_on = right_en_r;
  assign out_chan.left_pwm_on  = left_en_r;
  assign out_chan.timebase_on  = timebase_r;
  assign out_chan.duty         = duty_r;
  assign out_chan.busy_res     = active_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `RPBG_ASSERT_NOW(a_busy_one_relay, active_r, $onehot(relays_r))
  `RPBG_ASSERT_NOW(a_idle_no_relay, !active_r, relays_r == '0)
  `RPBG_ASSERT_NOW(a_timebase_gates, 1'b1, timebase_r == (right_en_r || left_en_r))
  `RPBG_ASSERT_NOW(a_inten_sat, 1'b1, inten_r <= MAX_INTENSITY)
  `RPBG_ASSERT_NEXT(a_stall_holds, out_valid_r && !out_chan.ready,
                    $stable(duty_r) && $stable(relays_r) && $stable(phase_r))

endmodule

### test/rpbg_checker.sv
// Scoreboard for the relay pulse burst gate: predicts each result and compares it.
`timescale 1ns / 100ps

module rpbg_checker
  import rpbg_pkg::*;
#(
  parameter int NUM_PODS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  rpbg_in_if                  in_mon,
  rpbg_out_if                 out_mon,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_wdata,
  output int                  fail_count,
  output int                  pending,
  output int                  checked
);

  localparam int DUTY_DIV    = 144;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [RELAY_W-1:0] relay_mask;
    logic               right_pwm_on;
    logic               left_pwm_on;
    logic               timebase_on;
    logic [DUTY_W-1:0]  duty;
    logic               busy;
  } gate_view_t;

  gate_view_t gate_view_q[$];

  // predicted block state
  logic [PERIOD_W-1:0] period;
  logic                burst_on;
  logic [POD_W-1:0]    burst_pod;
  logic [RELAY_W-1:0]  relay_bits;
  logic                right_gate;
  logic                left_gate;
  logic                timebase_run;
  logic [INTEN_W-1:0]  burst_inten;
  logic [DUR_W-1:0]    ticks_left;
  logic [PHASE_W-1:0]  phase_count;
  logic                on_phase;
  logic [DUTY_W-1:0]   duty_hold;

  function automatic void clear_state();
    period       = PERIOD_RESET;
    burst_on     = 1'b0;
    burst_pod    = '0;
    relay_bits   = '0;
    right_gate   = 1'b0;
    left_gate    = 1'b0;
    timebase_run = 1'b0;
    burst_inten  = MAX_INTENSITY;
    ticks_left   = '0;
    phase_count  = '0;
    on_phase     = 1'b0;
    duty_hold    = '0;
  endfunction

  function automatic void gates_on(input logic [POD_W-1:0] pod);
    if (int'(pod) < NUM_PODS / 2)
      right_gate = 1'b1;
    else
      left_gate = 1'b1;
    timebase_run = 1'b1;
  endfunction

  function automatic void gates_off();
    right_gate   = 1'b0;
    left_gate    = 1'b0;
    timebase_run = 1'b0;
  endfunction

  function automatic void halt_all();
    gates_off();
    relay_bits = '0;
    burst_on   = 1'b0;
    ticks_left = '0;
    on_phase   = 1'b0;
  endfunction

  function automatic void start_burst(input logic [POD_W-1:0]   pod,
                                      input logic [FREQ_W-1:0]  freq,
                                      input logic [DUR_W-1:0]   dur,
                                      input logic [INTEN_W-1:0] inten);
    logic [31:0] scaled;
    if (int'(pod) >= NUM_PODS)
      return;
    relay_bits      = '0;
    relay_bits[pod] = 1'b1;
    scaled    = (32'(period) * 32'(freq)) / 32'(DUTY_DIV);
    duty_hold = (scaled > 32'hFFFF) ? 16'hFFFF : scaled[DUTY_W-1:0];
    gates_on(pod);
    burst_on    = 1'b1;
    burst_pod   = pod;
    burst_inten = (inten > MAX_INTENSITY) ? MAX_INTENSITY : inten;
    ticks_left  = dur;
    phase_count = '0;
    on_phase    = 1'b1;
  endfunction

  function automatic void advance_tick();
    int on_len;
    int off_len;
    if (!burst_on)
      return;
    phase_count = phase_count + 1'b1;
    on_len  = int'(burst_inten) * ON_SCALE;
    off_len = CYCLE_TICKS - on_len;
    if (on_phase) begin
      if (int'(phase_count) >= on_len) begin
        gates_off();
        on_phase    = 1'b0;
        phase_count = '0;
      end
    end else if (int'(phase_count) >= off_len) begin
      gates_on(burst_pod);
      on_phase    = 1'b1;
      phase_count = '0;
    end
    if (ticks_left != '0) begin
      if (ticks_left > 1)
        ticks_left = ticks_left - 1'b1;
      else
        halt_all();
    end
  endfunction

  always @(posedge clk) begin : watch
    gate_view_t got;
    gate_view_t want;
    if (!rst_n) begin
      clear_state();
      gate_view_q.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      // config is only written while idle, so it can take effect right here
      if (cfg_we)
        period = cfg_wdata;
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.cmd)
          CMD_TICK: advance_tick();
          CMD_FIRE: start_burst(in_mon.pod, in_mon.freq_value, in_mon.duration_ticks,
                                in_mon.intensity_pct);
          CMD_STOP: halt_all();
          default: ;
        endcase
        gate_view_q.push_back('{relay_bits, right_gate, left_gate, timebase_run,
                                duty_hold, burst_on});
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.relay_mask, out_mon.right_pwm_on, out_mon.left_pwm_on,
                out_mon.timebase_on, out_mon.duty, out_mon.busy_res};
        if (gate_view_q.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $display("%0t: unexpected result relays=%b R=%b L=%b tb=%b duty=%0d busy=%b",
                     $realtime, got.relay_mask, got.right_pwm_on, got.left_pwm_on,
                     got.timebase_on, got.duty, got.busy);
          fail_count++;
        end else begin
          want = gate_view_q.pop_front();
          if (got !== want) begin
            if (fail_count < REPORT_MAX) begin
              $display("%0t: result %0d mismatch", $realtime, checked);
              $display("  expected relays=%b R=%b L=%b tb=%b duty=%0d busy=%b",
                       want.relay_mask, want.right_pwm_on, want.left_pwm_on,
                       want.timebase_on, want.duty, want.busy);
              $display("  actual   relays=%b R=%b L=%b tb=%b duty=%0d busy=%b",
                       got.relay_mask, got.right_pwm_on, got.left_pwm_on,
                       got.timebase_on, got.duty, got.busy);
            end
            fail_count++;
          end
          checked++;
        end
      end
    end
    pending = gate_view_q.size();
  end

endmodule

### test/tb_relay_pulse_burst_gate.sv
// Testbench top for the relay pulse burst gate: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_relay_pulse_burst_gate;
  import rpbg_pkg::*;

  localparam int   NUM_PODS         = 6;
  localparam cmd_t CMD_RESERVED     = 2'd3;   // no defined behavior, must be a no-op
  localparam int   RESET_CYCLES     = 12;
  localparam int   CYCLE_LIMIT      = 300000;
  localparam int   SETTLE_CYCLES    = 6;      // result passes the input register, then the state registers
  localparam int   RANDOM_PER_PHASE = 100;
  localparam int   LONG_BURST_TICKS = 1010;   // one full on/off cycle is 1000 ticks
  localparam int   HOLD_CYCLES      = 80;
  localparam int   HOLD_ITEMS       = 30;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [PERIOD_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int checked;
  int sent;
  int cycle_count;
  int periods_used;
  int snd_idle_pct;     // chance per cycle that the sender leaves valid low
  int rcv_stall_pct;    // chance per cycle that the receiver drops ready
  int hold_left;
  bit hold_req;

  rpbg_in_if  in_chan ();
  rpbg_out_if out_chan ();

  relay_pulse_burst_gate #(
    .NUM_PODS (NUM_PODS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  rpbg_checker #(
    .NUM_PODS (NUM_PODS)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: a hung handshake or lost result ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Result side. Ready changes on the falling edge only. A hold request parks
  // ready low for HOLD_CYCLES so the pipeline backs up into the input channel.
  initial begin
    out_chan.ready = 1'b0;
    hold_left      = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // Present one transaction, wait for the handshake, then maybe idle a while.
  // Entered and left on a falling edge.
  task automatic send_item(input cmd_t                cmd,
                           input logic [POD_W-1:0]   pod,
                           input logic [FREQ_W-1:0]  freq,
                           input logic [DUR_W-1:0]   dur,
                           input logic [INTEN_W-1:0] inten);
    in_chan.valid          <= 1'b1;
    in_chan.cmd            <= cmd;
    in_chan.pod            <= pod;
    in_chan.freq_value     <= freq;
    in_chan.duration_ticks <= dur;
    in_chan.intensity_pct  <= inten;
    do @(posedge clk); while (!in_chan.ready);
    sent++;
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Ticks, stops and reserved codes ignore the payload; fill it with noise anyway.
  task automatic send_bare(input cmd_t cmd);
    send_item(cmd, POD_W'($urandom()), FREQ_W'($urandom()), DUR_W'($urandom()),
              INTEN_W'($urandom()));
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    periods_used++;
  endtask

  function automatic logic [POD_W-1:0] pick_pod();
    if ($urandom_range(9) == 0)
      return POD_W'($urandom_range(7, NUM_PODS));   // out of range, ignored
    return POD_W'($urandom_range(NUM_PODS - 1));
  endfunction

  function automatic logic [FREQ_W-1:0] pick_freq();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return FREQ_W'($urandom_range(255));
      default: return FREQ_W'($urandom());
    endcase
  endfunction

  // Mostly short or endless bursts so auto-stop lands inside the tick runs.
  function automatic logic [DUR_W-1:0] pick_dur();
    case ($urandom_range(9))
      0, 1, 2: return '0;
      3, 4:    return DUR_W'($urandom_range(1, 4));
      5, 6, 7: return DUR_W'($urandom_range(5, 60));
      default: return DUR_W'($urandom());
    endcase
  endfunction

  // 0 percent flips phase on the first tick; 1..3 percent flip within a short
  // run; above 100 checks the clamp.
  function automatic logic [INTEN_W-1:0] pick_inten();
    case ($urandom_range(7))
      0:       return '0;
      1:       return MAX_INTENSITY;
      2:       return INTEN_W'($urandom_range(127, 101));
      3:       return INTEN_W'($urandom_range(1, 3));
      4:       return INTEN_W'($urandom_range(99, 97));
      default: return INTEN_W'($urandom());
    endcase
  endfunction

  // Mostly fire-then-tick bursts with stray stops, refires and reserved codes
  // mixed in; the rest is raw noise on every field.
  task automatic run_random(input int n_items);
    int stop_at;
    int run_len;
    stop_at = sent + n_items;
    while (sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        send_item(CMD_FIRE, pick_pod(), pick_freq(), pick_dur(), pick_inten());
        run_len = $urandom_range(3, 40);
        repeat (run_len) begin
          case ($urandom_range(49))
            0:       send_bare(CMD_STOP);
            1:       send_bare(CMD_RESERVED);
            2:       send_item(CMD_FIRE, pick_pod(), pick_freq(), pick_dur(), pick_inten());
            default: send_bare(CMD_TICK);
          endcase
        end
      end else begin
        send_item(cmd_t'($urandom_range(3)), POD_W'($urandom()), FREQ_W'($urandom()),
                  DUR_W'($urandom()), INTEN_W'($urandom()));
      end
    end
  endtask

  task automatic run_phase(input int snd, input int rcv,
                           input logic [PERIOD_W-1:0] period, input int n_items);
    wait_drained();
    snd_idle_pct  = snd;
    rcv_stall_pct = rcv;
    write_period(period);
    run_random(n_items);
  endtask

  initial begin
    int saved_idle;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    in_chan.valid          = 1'b0;
    in_chan.cmd            = CMD_TICK;
    in_chan.pod            = '0;
    in_chan.freq_value     = '0;
    in_chan.duration_ticks = '0;
    in_chan.intensity_pct  = '0;
    snd_idle_pct           = 0;
    rcv_stall_pct          = 0;
    hold_req               = 1'b0;
    sent                   = 0;
    periods_used           = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed: corner cases at the reset period of 93 ----
    send_bare(CMD_TICK);                                   // tick while idle
    send_bare(CMD_STOP);                                   // stop while idle
    send_bare(CMD_RESERVED);                               // reserved code
    send_item(CMD_FIRE, 3'd6, '1, '1, '1);                 // pod out of range
    send_item(CMD_FIRE, 3'd7, '1, '1, '1);
    send_item(CMD_FIRE, 3'd0, '1, '0, 7'd127);             // max freq, clamp, endless
    send_bare(CMD_TICK);
    send_item(CMD_FIRE, 3'd5, 16'd1, 16'd3, 7'd0);         // refire other side while busy
    send_bare(CMD_TICK);                                   // zero on-time: gates drop
    send_bare(CMD_TICK);
    send_bare(CMD_TICK);                                   // duration runs out
    send_bare(CMD_TICK);                                   // idle again
    send_item(CMD_FIRE, 3'd3, '0, '0, MAX_INTENSITY);      // zero duty, full on
    send_bare(CMD_TICK);
    send_bare(CMD_STOP);                                   // stop keeps duty
    send_item(CMD_FIRE, 3'd2, 16'd144, 16'd1, 7'd1);       // one-tick burst
    send_bare(CMD_TICK);
    send_item(CMD_FIRE, 3'd1, 16'd12345, '1, 7'd55);       // longest duration
    send_item(CMD_FIRE, 3'd4, '1, 16'd2, 7'd101);          // just above the clamp
    send_bare(CMD_TICK);
    send_bare(CMD_STOP);
    send_item(CMD_RESERVED, '1, '1, '1, '1);

    // ---- phase 0: no idling, reset period; one burst held for a full cycle
    // so the off phase actually hands back to the on phase ----
    send_item(CMD_FIRE, POD_W'($urandom_range(NUM_PODS - 1)), FREQ_W'($urandom()), '0,
              INTEN_W'($urandom_range(1, 3)));
    repeat (LONG_BURST_TICKS) send_bare(CMD_TICK);
    send_bare(CMD_STOP);
    run_random(RANDOM_PER_PHASE);

    // ---- phases 1..4: pacing modes crossed with period settings ----
    run_phase(69, 0, '1, RANDOM_PER_PHASE);                // top period: duty saturates
    run_phase(0, 69, 8'd1, RANDOM_PER_PHASE);              // bottom period
    run_phase(36, 36, PERIOD_W'($urandom_range(254, 2)), RANDOM_PER_PHASE);

    // Back-pressure: output parked while input keeps offering, so the
    // pipeline fills and in_chan.ready must drop.
    saved_idle   = snd_idle_pct;
    snd_idle_pct = 0;
    hold_req     = 1'b1;
    repeat (HOLD_ITEMS) send_bare(CMD_TICK);
    snd_idle_pct = saved_idle;
    // Sender pause mid-phase until the block is fully drained.
    wait_drained();
    run_random(RANDOM_PER_PHASE / 2);

    run_phase(0, 0, PERIOD_RESET, RANDOM_PER_PHASE);       // back to the reset value

    wait_drained();

    $display("Summary: %0d transactions sent, %0d results checked, %0d period writes",
             sent, checked, periods_used);
    $display("  idle and stall pacing mixes, a long output stall, full burst cycle");
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
